// File: rtl/core/npcs_pkg.sv
// Shared types, constants and helpers for the nearest palette color search unit.
// No dependencies; imported by every module of the block.
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W             = 8;
    localparam int INDEX_W             = 8;
    localparam int SQ_W                = 16;
    localparam int DIST_W              = 18;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    // Tag that travels with each palette read through the scan pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_scan_ctl;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// File: rtl/core/npcs_palette_ram.sv
// Palette storage: one write port, one registered read port.
// Depends on npcs_pkg for the entry type.
module npcs_palette_ram
    import npcs_pkg::*;
#(
    parameter int ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_rgb          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_rgb          o_rd_data
);

    t_rgb r_mem [ENTRIES];
    t_rgb r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/npcs_dist_unit.sv
// Shared distance unit: squares the channel differences of one entry per cycle,
// then sums and keeps the running minimum. Depends on npcs_pkg.
module npcs_dist_unit
    import npcs_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rgb              i_query,
    input  t_rgb              i_entry,
    input  t_scan_ctl         i_ctl,
    input  logic [AW-1:0]     i_idx,
    output logic [AW-1:0]     o_best_idx,
    output logic [DIST_W-1:0] o_best_dist,
    output logic              o_done
);

    logic [SQ_W-1:0]   r_sq_r;
    logic [SQ_W-1:0]   r_sq_g;
    logic [SQ_W-1:0]   r_sq_b;
    logic [AW-1:0]     r_sq_idx;
    t_scan_ctl         r_sq_ctl;
    logic [DIST_W-1:0] n_sum;
    logic [AW-1:0]     r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_done;

    // Square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl <= '0;
        end else begin
            r_sq_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_r   <= sq_diff(i_query.red,   i_entry.red);
        r_sq_g   <= sq_diff(i_query.green, i_entry.green);
        r_sq_b   <= sq_diff(i_query.blue,  i_entry.blue);
        r_sq_idx <= i_idx;
    end

    // Sum and compare stage; strict less-than keeps the lowest index on a tie
    assign n_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (r_sq_ctl.valid && (r_sq_ctl.first || (n_sum < r_best_dist))) begin
            r_best_idx  <= r_sq_idx;
            r_best_dist <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sq_ctl.valid && r_sq_ctl.last;
        end
    end

    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;
    assign o_done      = r_done;

endmodule

// File: rtl/core/nearest_palette_color_search_unit.sv
// Top level of the nearest palette color search unit: request sequencer,
// palette RAM and shared distance unit. Depends on npcs_pkg, npcs_palette_ram, npcs_dist_unit.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------
//  request  | in        | i_valid / o_ready    | i_cmd, i_entry_index, i_red/green/blue
//  result   | out       | o_valid / i_ready    | o_nearest_index, o_best_distance
//
// A palette write produces no result.
// A query holds o_ready low while the sequencer scans the palette, one palette RAM
// read per cycle, then through the RAM, square, compare and done registers and the
// output load; the next request is taken only after that at the earliest.
// o_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next request can be taken while it waits. A query that
// finishes while that register is still full holds until i_ready drains it.
// Reset is synchronous, active low; palette contents are undefined until written.
module nearest_palette_color_search_unit
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [INDEX_W-1:0] i_entry_index,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [INDEX_W-1:0] o_nearest_index,
    output logic [DIST_W-1:0]  o_best_distance
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      n_addr;
    t_rgb               r_query;
    t_rgb               w_in_rgb;
    logic               w_accept;
    logic               w_wr_en;
    logic               w_rd_en;
    t_scan_ctl          w_rd_ctl;
    t_scan_ctl          r_rd_ctl;
    logic [AW-1:0]      r_rd_idx;
    t_rgb               w_rd_data;
    logic [AW-1:0]      w_best_idx;
    logic [DIST_W-1:0]  w_best_dist;
    logic               w_done;
    logic               w_load_out;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [DIST_W-1:0]  r_out_dist;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_in_rgb = '{red: i_red, green: i_green, blue: i_blue};

    // Drop writes that fall outside the palette
    assign w_wr_en = w_accept && (i_cmd == CMD_WRITE)
                     && (32'(i_entry_index) < 32'(PALETTE_ENTRIES));

    assign w_rd_en        = (r_state == ST_SCAN);
    assign w_rd_ctl.valid = w_rd_en;
    assign w_rd_ctl.first = (r_addr == '0);
    assign w_rd_ctl.last  = (r_addr == AW'(PALETTE_ENTRIES - 1));

    assign w_load_out = (r_state == ST_HOLD) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == CMD_QUERY)) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (w_rd_ctl.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= w_rd_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_idx <= r_addr;
        if (w_accept && (i_cmd == CMD_QUERY)) begin
            r_query <= w_in_rgb;
        end
    end

    npcs_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (w_in_rgb),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    npcs_dist_unit #(
        .AW (AW)
    ) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query     (r_query),
        .i_entry     (w_rd_data),
        .i_ctl       (r_rd_ctl),
        .i_idx       (r_rd_idx),
        .o_best_idx  (w_best_idx),
        .o_best_dist (w_best_dist),
        .o_done      (w_done)
    );

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_index <= INDEX_W'(w_best_idx);
            r_out_dist  <= w_best_dist;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_nearest_index = r_out_index;
    assign o_best_distance = r_out_dist;

endmodule
